// ===== design/spfg_pkg.sv =====
// Shared constants and helpers for the six-pulse firing generator.
// Used by spfg_leg and six_pulse_firing_generator; depends on nothing.
package spfg_pkg;

   // Thyristor legs in a six-pulse bridge
   localparam int LEGS = 6;

   // Width of the angle and pulse-width ports
   localparam int FIELD_W = 16;

   // Default datapath widths
   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int LIMIT_BITS_DEFAULT = 18;

   // Pulse width after reset, in fractions of a turn
   localparam logic [FIELD_W-1:0] PULSE_WIDTH_RESET = 16'd1024;

   // Ramp offset of thyristor k: 30 degrees plus (6-k)*60 degrees, i.e.
   // (2*(6-k)+1)/12 of a turn, rounded to nearest with halves up.
   function automatic logic [63:0] leg_offset(input int k, input int angle_bits);
      logic [63:0] turn;
      logic [63:0] twelfths;
      turn     = 64'd1 << angle_bits;
      twelfths = 64'(2 * (LEGS - k) + 1);
      return (turn * twelfths + 64'd6) / 64'd12;
   endfunction

endpackage

// ===== design/six_pulse_firing_generator.sv =====
// Top level of the six-pulse thyristor bridge firing pulse generator.
// Depends on spfg_pkg and spfg_leg.
//
//   Channel  Ports                                        Direction  Transfer when
//   req      req_valid/req_ready, phase, angle, inhibit   in         valid & ready
//   rsp      rsp_valid/rsp_ready, gate_pulses             out        valid & ready
//   csr      csr_write_enable, csr_write_data             in         write enable
//
// One sample per cycle sustained while rsp_ready stays high; a result passes through
// the input register and then the result register before it can transfer out.
// Synchronous active-high reset clears valids and pulse limits and restores the
// pulse width to its reset value.
// A stalled result holds the result register; the input register still drains
// into it once it is taken, so at most two samples are in flight.
module six_pulse_firing_generator #(
   parameter int ANGLE_BITS = spfg_pkg::ANGLE_BITS_DEFAULT,
   parameter int LIMIT_BITS = spfg_pkg::LIMIT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [spfg_pkg::FIELD_W-1:0]       req_phase,
   input  logic [spfg_pkg::FIELD_W-1:0]       req_firing_angle,
   input  logic                               req_inhibit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spfg_pkg::LEGS-1:0]          rsp_gate_pulses,
   input  logic                               csr_write_enable,
   input  logic [spfg_pkg::FIELD_W-1:0]       csr_write_data
);
   import spfg_pkg::*;

   localparam int EXT_W = FIELD_W + ANGLE_BITS;

   logic                  s1_valid_ff;
   logic [ANGLE_BITS-1:0] s1_phase_ff;
   logic [ANGLE_BITS-1:0] s1_alpha_ff;
   logic                  s1_inhibit_ff;
   logic                  rsp_valid_ff;
   logic [LEGS-1:0]       rsp_pulses_ff;
   logic [LEGS-1:0]       rsp_pulses_in;
   logic [FIELD_W-1:0]    pulse_width_ff;
   logic [LEGS-1:0]       leg_pulses;
   logic [EXT_W-1:0]      phase_ext;
   logic [EXT_W-1:0]      alpha_ext;
   logic                  advance;
   logic                  req_take;

   // Keep only the low ANGLE_BITS of the angles, zero-extended if wider
   assign phase_ext = EXT_W'(req_phase);
   assign alpha_ext = EXT_W'(req_firing_angle);

   // Handshake control
   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | ~rsp_valid_ff | rsp_ready;
   assign req_take  = req_valid & req_ready;

   // Pulse width register
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= PULSE_WIDTH_RESET;
      end else if (csr_write_enable) begin
         pulse_width_ff <= csr_write_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_phase_ff   <= phase_ext[ANGLE_BITS-1:0];
         s1_alpha_ff   <= alpha_ext[ANGLE_BITS-1:0];
         s1_inhibit_ff <= req_inhibit;
      end
   end

   // Six legs, each with its own ramp offset and limit
   for (genvar g = 0; g < LEGS; g++) begin : g_leg
      localparam logic [ANGLE_BITS-1:0] OFF = ANGLE_BITS'(leg_offset(g + 1, ANGLE_BITS));
      spfg_leg #(
         .ANGLE_BITS (ANGLE_BITS),
         .LIMIT_BITS (LIMIT_BITS),
         .OFFSET     (OFF)
      ) u_leg (
         .clock       (clock),
         .reset       (reset),
         .update      (advance),
         .phase       (s1_phase_ff),
         .alpha       (s1_alpha_ff),
         .pulse_width (pulse_width_ff),
         .pulse       (leg_pulses[g])
      );
   end

   // Drop all gate pulses while inhibited
   assign rsp_pulses_in = s1_inhibit_ff ? '0 : leg_pulses;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pulses_ff <= rsp_pulses_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gate_pulses = rsp_pulses_ff;

   // Checks
   a_inhibit_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s1_inhibit_ff |=> rsp_gate_pulses == '0)
      else $error("inhibited sample produced gate pulses");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register not loaded after advance");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("empty input register not ready");

   a_result_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !advance |=> rsp_valid)
      else $error("stalled result dropped");

endmodule

// ===== design/spfg_leg.sv =====
// One thyristor leg: ramp, firing window compare and pulse limit register.
// Depends on spfg_pkg.
module spfg_leg #(
   parameter int ANGLE_BITS = spfg_pkg::ANGLE_BITS_DEFAULT,
   parameter int LIMIT_BITS = spfg_pkg::LIMIT_BITS_DEFAULT,
   parameter logic [ANGLE_BITS-1:0] OFFSET = '0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic [ANGLE_BITS-1:0]         phase,
   input  logic [ANGLE_BITS-1:0]         alpha,
   input  logic [spfg_pkg::FIELD_W-1:0]  pulse_width,
   output logic                          pulse
);
   import spfg_pkg::*;

   localparam int BASE_W = (ANGLE_BITS > LIMIT_BITS) ? ANGLE_BITS : LIMIT_BITS;
   localparam int SUM_W  = BASE_W + 1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

   logic [LIMIT_BITS-1:0] limit_ff;
   logic [LIMIT_BITS-1:0] limit_in;
   logic [ANGLE_BITS-1:0] ramp;
   logic                  cond_a;
   logic                  cond_b;
   logic [SUM_W-1:0]      base;
   logic [SUM_W-1:0]      sum;

   // Form the ramp, wrapped to one turn
   assign ramp = phase + OFFSET;

   // Pulse window: past the firing angle and not beyond the old limit
   assign cond_a = (ramp >= alpha);
   assign cond_b = (SUM_W'(ramp) <= SUM_W'(limit_ff));
   assign pulse  = cond_a & cond_b;

   // Restart the limit at alpha once past the firing angle, otherwise stretch it; saturate
   always_comb begin
      base = cond_a ? SUM_W'(alpha) : SUM_W'(limit_ff);
      sum  = base + SUM_W'(pulse_width);
      if (sum > SUM_W'(LIMIT_MAX)) begin
         limit_in = LIMIT_MAX;
      end else begin
         limit_in = sum[LIMIT_BITS-1:0];
      end
   end

   // Hold the limit between samples
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (update) begin
         limit_ff <= limit_in;
      end
   end

endmodule
